@@ rtl/core/one_wire_bus_master_unit_defines.svh @@
// Assertion macros used by the checker file of the 1-Wire master.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low
`define OWM_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, quiet while rst_n is low
`define OWM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/owm_pkg.sv @@
// Shared types and codes of the 1-Wire bus master.
`default_nettype none

package owm_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_RESET = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_TOUCH = 3'd4;

  // Timing register file, all counts in microsecond ticks
  typedef struct packed {
    logic [9:0] short_low_time;
    logic [9:0] write_one_release;
    logic [9:0] write_zero_low;
    logic [9:0] write_zero_release;
    logic [9:0] read_sample_delay;
    logic [9:0] read_recovery;
    logic [9:0] reset_low_time;
    logic [9:0] presence_sample_delay;
  } cfg_t;

  // Input request
  typedef struct packed {
    logic [2:0] req_type;
    logic       bus_level;
    logic [7:0] tx_byte;
  } in_item_t;

  // Result of one request
  typedef struct packed {
    logic       bus_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_found;
    logic [7:0] rx_byte;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/owm_regs.sv @@
// APB-style timing register file of the 1-Wire master.
`default_nettype none

module owm_regs
  import owm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  localparam logic [2:0] REG_SHORT_LOW    = 3'd0;
  localparam logic [2:0] REG_W1_RELEASE   = 3'd1;
  localparam logic [2:0] REG_W0_LOW       = 3'd2;
  localparam logic [2:0] REG_W0_RELEASE   = 3'd3;
  localparam logic [2:0] REG_RD_SAMPLE    = 3'd4;
  localparam logic [2:0] REG_RD_RECOVERY  = 3'd5;
  localparam logic [2:0] REG_RST_LOW      = 3'd6;
  localparam logic [2:0] REG_PRES_SAMPLE  = 3'd7;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic [9:0] rd_val;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_low_time        <= 10'd6;
      cfg_r.write_one_release     <= 10'd64;
      cfg_r.write_zero_low        <= 10'd60;
      cfg_r.write_zero_release    <= 10'd10;
      cfg_r.read_sample_delay     <= 10'd9;
      cfg_r.read_recovery         <= 10'd55;
      cfg_r.reset_low_time        <= 10'd480;
      cfg_r.presence_sample_delay <= 10'd70;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SHORT_LOW:   cfg_r.short_low_time        <= pwdata[9:0];
        REG_W1_RELEASE:  cfg_r.write_one_release     <= pwdata[9:0];
        REG_W0_LOW:      cfg_r.write_zero_low        <= pwdata[9:0];
        REG_W0_RELEASE:  cfg_r.write_zero_release    <= pwdata[9:0];
        REG_RD_SAMPLE:   cfg_r.read_sample_delay     <= pwdata[9:0];
        REG_RD_RECOVERY: cfg_r.read_recovery         <= pwdata[9:0];
        REG_RST_LOW:     cfg_r.reset_low_time        <= pwdata[9:0];
        REG_PRES_SAMPLE: cfg_r.presence_sample_delay <= pwdata[9:0];
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_SHORT_LOW:   rd_val = cfg_r.short_low_time;
      REG_W1_RELEASE:  rd_val = cfg_r.write_one_release;
      REG_W0_LOW:      rd_val = cfg_r.write_zero_low;
      REG_W0_RELEASE:  rd_val = cfg_r.write_zero_release;
      REG_RD_SAMPLE:   rd_val = cfg_r.read_sample_delay;
      REG_RD_RECOVERY: rd_val = cfg_r.read_recovery;
      REG_RST_LOW:     rd_val = cfg_r.reset_low_time;
      REG_PRES_SAMPLE: rd_val = cfg_r.presence_sample_delay;
      default:         rd_val = 10'd0;
    endcase
  end

  assign prdata = {22'd0, rd_val};

endmodule

`default_nettype wire

@@ rtl/core/owm_core.sv @@
// Bus sequencer of the 1-Wire master: phase state, slot timing, result register.
`default_nettype none

module owm_core
  import owm_pkg::*;
#(
  parameter logic [9:0] RESET_PRE_DELAY = 10'd0,
  parameter logic [9:0] RESET_RECOVERY  = 10'd410
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  in_item_t       item,
  input  cfg_t           cfg,
  output out_item_t      res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_PRE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_SLOT_LOW,
    PH_SLOT_REL,
    PH_READ_WAIT,
    PH_READ_REC
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [9:0] cd;
    logic [2:0] idx;
    logic       done;
  } slot_t;

  // Start the slot at bit 'start' or beyond; slots that take no time at all
  // are passed over. A start of eight (or nothing left) ends the byte.
  function automatic slot_t enter_slot(input logic [2:0] op, input logic [7:0] tx,
                                       input logic [3:0] start, input cfg_t c);
    slot_t      s;
    logic [7:0] skip;
    logic       found;
    logic [2:0] j;
    logic       b;
    logic       rd;
    logic       z0;
    logic       z1;
    logic [9:0] low;
    logic [9:0] rel;
    z1 = (c.short_low_time == 10'd0) && (c.write_one_release == 10'd0);
    z0 = (c.write_zero_low == 10'd0) && (c.write_zero_release == 10'd0);
    for (int k = 0; k < 8; k++) begin
      skip[k] = (4'(k) < start) ||
                ((op == REQ_WRITE) ? (tx[k] ? z1 : z0) :
                 (op == REQ_TOUCH) ? (!tx[k] && z0) : 1'b0);
    end
    found = 1'b0;
    j     = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!skip[k]) begin
        found = 1'b1;
        j     = 3'(k);
      end
    end
    b   = tx[j];
    rd  = (op == REQ_READ) || ((op == REQ_TOUCH) && b);
    low = (rd || b) ? c.short_low_time : c.write_zero_low;
    rel = b ? c.write_one_release : c.write_zero_release;
    s.phase = PH_IDLE;
    s.cd    = 10'd0;
    s.idx   = j;
    s.done  = !found;
    if (found) begin
      if (low != 10'd0) begin
        s.phase = PH_SLOT_LOW;
        s.cd    = low;
      end else if (rd) begin
        s.phase = PH_READ_WAIT;
        s.cd    = c.read_sample_delay;
      end else begin
        s.phase = PH_SLOT_REL;
        s.cd    = rel;
      end
    end
    return s;
  endfunction

  phase_t     phase_r, phase_nxt;
  logic [9:0] cd_r, cd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic [2:0] op_r, op_nxt;
  logic       pres_r, pres_nxt;
  logic       done;
  out_item_t  res_r, res_nxt;

  slot_t      next_slot;
  slot_t      first_slot;
  logic       cur_bit;
  logic       cur_rd;
  logic [9:0] cur_rel;
  logic       tick_end;

  // bit after the current one, and first bit of a new byte
  assign next_slot  = enter_slot(op_r, tx_r, {1'b0, idx_r} + 4'd1, cfg);
  assign first_slot = enter_slot(item.req_type, item.tx_byte, 4'd0, cfg);
  assign cur_bit    = tx_r[idx_r];
  assign cur_rd     = (op_r == REQ_READ) || ((op_r == REQ_TOUCH) && cur_bit);
  assign cur_rel    = cur_bit ? cfg.write_one_release : cfg.write_zero_release;
  assign tick_end   = (cd_r <= 10'd1);

  // next state for the request in hand
  always_comb begin
    phase_nxt = phase_r;
    cd_nxt    = cd_r;
    idx_nxt   = idx_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    op_nxt    = op_r;
    pres_nxt  = pres_r;
    done      = 1'b0;
    case (item.req_type)
      REQ_TICK: begin
        case (phase_r)
          PH_IDLE: ;
          PH_RST_WAIT: begin
            if (cd_r == 10'd0) begin
              pres_nxt = ~item.bus_level;
              if (RESET_RECOVERY != 10'd0) begin
                phase_nxt = PH_RST_REC;
                cd_nxt    = RESET_RECOVERY;
              end else begin
                phase_nxt = PH_IDLE;
                cd_nxt    = 10'd0;
                done      = 1'b1;
              end
            end else begin
              cd_nxt = cd_r - 10'd1;
            end
          end
          PH_READ_WAIT: begin
            if (cd_r == 10'd0) begin
              rx_nxt[idx_r] = item.bus_level;
              if (cfg.read_recovery != 10'd0) begin
                phase_nxt = PH_READ_REC;
                cd_nxt    = cfg.read_recovery;
              end else begin
                phase_nxt = next_slot.phase;
                cd_nxt    = next_slot.cd;
                idx_nxt   = next_slot.idx;
                done      = next_slot.done;
              end
            end else begin
              cd_nxt = cd_r - 10'd1;
            end
          end
          PH_RST_PRE: begin
            if (!tick_end) begin
              cd_nxt = cd_r - 10'd1;
            end else if (cfg.reset_low_time != 10'd0) begin
              phase_nxt = PH_RST_LOW;
              cd_nxt    = cfg.reset_low_time;
            end else begin
              phase_nxt = PH_RST_WAIT;
              cd_nxt    = cfg.presence_sample_delay;
            end
          end
          PH_RST_LOW: begin
            if (!tick_end) begin
              cd_nxt = cd_r - 10'd1;
            end else begin
              phase_nxt = PH_RST_WAIT;
              cd_nxt    = cfg.presence_sample_delay;
            end
          end
          PH_RST_REC: begin
            if (!tick_end) begin
              cd_nxt = cd_r - 10'd1;
            end else begin
              phase_nxt = PH_IDLE;
              cd_nxt    = 10'd0;
              done      = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            if (!tick_end) begin
              cd_nxt = cd_r - 10'd1;
            end else if (cur_rd) begin
              phase_nxt = PH_READ_WAIT;
              cd_nxt    = cfg.read_sample_delay;
            end else if (cur_rel != 10'd0) begin
              phase_nxt = PH_SLOT_REL;
              cd_nxt    = cur_rel;
            end else begin
              phase_nxt = next_slot.phase;
              cd_nxt    = next_slot.cd;
              idx_nxt   = next_slot.idx;
              done      = next_slot.done;
            end
          end
          PH_SLOT_REL, PH_READ_REC: begin
            if (!tick_end) begin
              cd_nxt = cd_r - 10'd1;
            end else begin
              phase_nxt = next_slot.phase;
              cd_nxt    = next_slot.cd;
              idx_nxt   = next_slot.idx;
              done      = next_slot.done;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            cd_nxt    = 10'd0;
          end
        endcase
      end
      REQ_RESET: begin
        if (phase_r == PH_IDLE) begin
          op_nxt   = REQ_RESET;
          idx_nxt  = 3'd0;
          rx_nxt   = 8'd0;
          tx_nxt   = 8'd0;
          pres_nxt = 1'b0;
          if (RESET_PRE_DELAY != 10'd0) begin
            phase_nxt = PH_RST_PRE;
            cd_nxt    = RESET_PRE_DELAY;
          end else if (cfg.reset_low_time != 10'd0) begin
            phase_nxt = PH_RST_LOW;
            cd_nxt    = cfg.reset_low_time;
          end else begin
            phase_nxt = PH_RST_WAIT;
            cd_nxt    = cfg.presence_sample_delay;
          end
        end
      end
      REQ_WRITE, REQ_READ, REQ_TOUCH: begin
        if (phase_r == PH_IDLE) begin
          op_nxt    = item.req_type;
          rx_nxt    = 8'd0;
          tx_nxt    = item.tx_byte;
          phase_nxt = first_slot.phase;
          cd_nxt    = first_slot.cd;
          idx_nxt   = first_slot.idx;
          done      = first_slot.done;
        end
      end
      default: ;
    endcase
  end

  // result fields from the state after the request
  always_comb begin
    res_nxt.bus_pull_low   = (phase_nxt inside {PH_RST_LOW, PH_SLOT_LOW});
    res_nxt.busy_res       = (phase_nxt != PH_IDLE);
    res_nxt.done_res       = done;
    res_nxt.presence_found = done && (op_nxt == REQ_RESET) && pres_nxt;
    res_nxt.rx_byte        = (done && ((op_nxt == REQ_READ) || (op_nxt == REQ_TOUCH)))
                             ? rx_nxt : 8'd0;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cd_r    <= 10'd0;
      idx_r   <= 3'd0;
      tx_r    <= 8'd0;
      rx_r    <= 8'd0;
      op_r    <= 3'd0;
      pres_r  <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      idx_r   <= idx_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      op_r    <= op_nxt;
      pres_r  <= pres_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ rtl/core/one_wire_bus_master_unit.sv @@
// Top level of the 1-Wire bus master: request and result channels, timing registers.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in_     | in        | in_valid/in_stall  | in_item_t (request, tick level)
//  out_    | out       | out_valid/out_stall| out_item_t (wire drive, status)
//  cfg     | in        | psel/penable/pready| 10-bit timing registers
//
// One request is taken per cycle while the result side does not stall; its result
// passes the input register, then the sequencer and result register.
// Zero-length low, release and recovery phases are folded within the same cycle.
// A stall on the result side holds both registers; requests keep flowing
// while the result register is free. Synchronous reset, active low.
`default_nettype none

module one_wire_bus_master_unit
  import owm_pkg::*;
#(
  parameter logic [9:0] RESET_PRE_DELAY = 10'd0,
  parameter logic [9:0] RESET_RECOVERY  = 10'd410
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic     in_valid_r;
  in_item_t in_data_r;
  logic     out_valid_r;
  logic     adv;
  cfg_t     cfg;

  // request moves on when the result register is empty or being taken
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
      in_data_r  <= in_data;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  owm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owm_core #(
    .RESET_PRE_DELAY (RESET_PRE_DELAY),
    .RESET_RECOVERY  (RESET_RECOVERY)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/owm_checker.sv @@
// Port-level checks of the 1-Wire master and their bind to the top level.
`default_nettype none
`include "one_wire_bus_master_unit_defines.svh"

module owm_checker
  import owm_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input out_item_t out_data
);

  // a held result stays put
  `OWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")

  // requests only back up behind a held result
  `OWM_ASSERT_NOW(a_in_stall_cause, in_valid && in_stall, out_valid && out_stall, "input stalled without output stall")

  // a finished operation leaves the bus idle
  `OWM_ASSERT_NOW(a_done_idle, out_valid && out_data.done_res, !out_data.busy_res, "done while still busy")

  // wire is only driven low during an operation
  `OWM_ASSERT_NOW(a_pull_busy, out_valid && out_data.bus_pull_low, out_data.busy_res, "wire pulled low while idle")

  // presence is only reported on completion
  `OWM_ASSERT_NOW(a_pres_done, out_valid && out_data.presence_found, out_data.done_res, "presence without done")

endmodule

bind one_wire_bus_master_unit owm_checker u_owm_checker (.*);

`default_nettype wire
